@@ sv/css_pkg.sv @@
package css_pkg;

   // Request codes.
   localparam logic [3:0] OP_START    = 4'd0;
   localparam logic [3:0] OP_END      = 4'd1;
   localparam logic [3:0] OP_ADVANCE  = 4'd2;
   localparam logic [3:0] OP_INSERT   = 4'd3;
   localparam logic [3:0] OP_ATTACH   = 4'd4;
   localparam logic [3:0] OP_REMOVE   = 4'd5;
   localparam logic [3:0] OP_INSFRONT = 4'd6;
   localparam logic [3:0] OP_ATTBACK  = 4'd7;
   localparam logic [3:0] OP_REMFRONT = 4'd8;
   localparam logic [3:0] OP_READ     = 4'd9;
   localparam logic [3:0] OP_READAT   = 4'd10;

   // Status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   // Kind of memory work a request needs.
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_INS  = 2'd2;
   localparam logic [1:0] KIND_DEL  = 2'd3;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [63:0] entry;
      logic [5:0]  spot;
   } css_req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [6:0]  count;
      logic [6:0]  cursor;
      logic        has_item;
      logic [1:0]  status;
   } css_rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic fill;
      logic read;
   } css_cmd_type;

   typedef struct packed {
      logic [1:0] next_kind;
      logic [1:0] kind;
      logic       shift_done;
   } css_stat_type;

endpackage

@@ sv/css_ctrl.sv @@
module css_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  css_pkg::css_stat_type stat,
   output logic                 busy,
   output logic                 rsp_valid,
   output css_pkg::css_cmd_type  cmd
);
   import css_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_RDMEM = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (stat.next_kind)
                  KIND_READ: state_in = S_RDMEM;
                  KIND_INS:  state_in = S_SHIFT;
                  KIND_DEL:  state_in = S_SHIFT;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = (stat.kind == KIND_INS) ? S_FILL : S_RESP;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_RESP;
         end
         S_RDMEM: begin
            cmd.read = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef ASSERT_OFF
   a_resp_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> (state_ff == S_IDLE))
      else $error("result strobe lasted more than one cycle");

   a_fill_after_ins: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (stat.kind == KIND_INS))
      else $error("fill issued for a request that inserts nothing");

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == S_IDLE))
      else $error("request loaded while another was in progress");
`endif
endmodule

@@ sv/css_dpath.sv @@
module css_dpath #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  css_pkg::css_req_type  req_payload,
   input  css_pkg::css_cmd_type  cmd,
   output css_pkg::css_stat_type stat,
   output css_pkg::css_rsp_type  rsp_payload
);
   import css_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [AW-1:0] ONE_A   = AW'(1);

   logic [63:0]   store_ff [DEPTH];
   logic [63:0]   rdata_ff;

   logic [CW-1:0] count_ff,  count_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [1:0]    status_ff, status_in;
   logic [1:0]    kind_ff,   kind_in;
   logic [CW-1:0] moves_ff,  moves_in;
   logic [AW-1:0] ra_ff,     ra_in;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] wa_ff;
   logic [63:0]   entry_ff;
   logic          pv_ff;

   logic [CW-1:0] pos_in;
   logic [CW-1:0] pos_p1;
   logic [CW-1:0] cnt_m1;
   logic          has_cur;
   logic          full;
   logic          empty;
   logic [CW+5:0] spot_ext;
   logic [CW+5:0] cnt_ext;
   logic [AW+5:0] spot_addr;
   logic [CW+6:0] cnt_wide;
   logic [CW+6:0] cur_wide;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;
   logic          rd_en;
   logic          more;
   logic          up;

   assign has_cur   = (cursor_ff < count_ff);
   assign full      = (count_ff == DEPTH_C);
   assign empty     = (count_ff == '0);
   assign spot_ext  = {{CW{1'b0}}, req_payload.spot};
   assign cnt_ext   = {6'b0, count_ff};
   assign spot_addr = {{AW{1'b0}}, req_payload.spot};
   assign cnt_m1    = count_ff - ONE_C;

   // Work out the new count and cursor, the status, and what the memory must do.
   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      status_in = ST_OK;
      kind_in   = KIND_NONE;
      pos_in    = '0;
      ra_in     = '0;
      moves_in  = '0;
      case (req_payload.req_type)
         OP_START: begin
            cursor_in = '0;
         end
         OP_END: begin
            if (empty) status_in = ST_NONE;
            else cursor_in = cnt_m1;
         end
         OP_ADVANCE: begin
            if (!has_cur) status_in = ST_NONE;
            else cursor_in = cursor_ff + ONE_C;
         end
         OP_INSERT: begin
            if (full) status_in = ST_FULL;
            else begin
               pos_in    = has_cur ? cursor_ff : '0;
               cursor_in = pos_in;
               count_in  = count_ff + ONE_C;
               kind_in   = KIND_INS;
            end
         end
         OP_ATTACH: begin
            if (full) status_in = ST_FULL;
            else begin
               pos_in    = has_cur ? cursor_ff + ONE_C : count_ff;
               cursor_in = pos_in;
               count_in  = count_ff + ONE_C;
               kind_in   = KIND_INS;
            end
         end
         OP_REMOVE: begin
            if (!has_cur) status_in = ST_NONE;
            else begin
               pos_in   = cursor_ff;
               count_in = cnt_m1;
               kind_in  = KIND_DEL;
            end
         end
         OP_INSFRONT: begin
            if (full) status_in = ST_FULL;
            else begin
               pos_in    = '0;
               cursor_in = '0;
               count_in  = count_ff + ONE_C;
               kind_in   = KIND_INS;
            end
         end
         OP_ATTBACK: begin
            if (full) status_in = ST_FULL;
            else begin
               pos_in    = count_ff;
               cursor_in = count_ff;
               count_in  = count_ff + ONE_C;
               kind_in   = KIND_INS;
            end
         end
         OP_REMFRONT: begin
            if (empty) status_in = ST_NONE;
            else begin
               pos_in    = '0;
               cursor_in = '0;
               count_in  = cnt_m1;
               kind_in   = KIND_DEL;
            end
         end
         OP_READ: begin
            if (!has_cur) status_in = ST_NONE;
            else begin
               kind_in = KIND_READ;
               ra_in   = cursor_ff[AW-1:0];
            end
         end
         OP_READAT: begin
            if (spot_ext >= cnt_ext) status_in = ST_NONE;
            else begin
               kind_in = KIND_READ;
               ra_in   = spot_addr[AW-1:0];
            end
         end
         default: begin
         end
      endcase

      // Insertion moves items from the top down; removal from the gap upwards.
      pos_p1 = pos_in + ONE_C;
      if (kind_in == KIND_INS) begin
         moves_in = count_ff - pos_in;
         ra_in    = cnt_m1[AW-1:0];
      end else if (kind_in == KIND_DEL) begin
         moves_in = cnt_m1 - pos_in;
         ra_in    = pos_p1[AW-1:0];
      end
   end

   assign up   = (kind_ff == KIND_INS);
   assign more = (moves_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         kind_ff   <= KIND_NONE;
         moves_ff  <= '0;
         pv_ff     <= 1'b0;
      end else if (cmd.load) begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         kind_ff   <= kind_in;
         moves_ff  <= moves_in;
         pv_ff     <= 1'b0;
      end else if (cmd.shift) begin
         pv_ff <= more;
         if (more) begin
            moves_ff <= moves_ff - ONE_C;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= status_in;
         pos_ff    <= pos_in[AW-1:0];
         ra_ff     <= ra_in;
         entry_ff  <= req_payload.entry;
      end else if (cmd.shift && more) begin
         ra_ff <= up ? ra_ff - ONE_A : ra_ff + ONE_A;
         wa_ff <= up ? ra_ff + ONE_A : ra_ff - ONE_A;
      end
   end

   // Store with one write port and one read port: one write and one registered read per cycle.
   assign wr_en   = (cmd.shift && pv_ff) || cmd.fill;
   assign wr_addr = cmd.fill ? pos_ff : wa_ff;
   assign wr_data = cmd.fill ? entry_ff : rdata_ff;
   assign rd_en   = (cmd.shift && more) || cmd.read;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[ra_ff];
      end
   end

   assign stat.next_kind  = kind_in;
   assign stat.kind       = kind_ff;
   assign stat.shift_done = !more;

   assign cnt_wide = {7'b0, count_ff};
   assign cur_wide = {7'b0, cursor_ff};

   assign rsp_payload.value    = (kind_ff == KIND_READ) ? rdata_ff : '0;
   assign rsp_payload.count    = cnt_wide[6:0];
   assign rsp_payload.cursor   = cur_wide[6:0];
   assign rsp_payload.has_item = has_cur;
   assign rsp_payload.status   = status_ff;

`ifndef ASSERT_OFF
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond item count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("item count beyond depth");

   a_fill_no_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> !pv_ff)
      else $error("fill collides with a pending shift write");
`endif
endmodule

@@ sv/cursor_sequence_store_core.sv @@
// A cursor-only request goes straight to its result, and a read first reads the store.
// A removal shifts the items above the gap down one place; an insertion shifts items up
// one place and then writes the new word into the gap. A new request is taken only once
// the last result has been given; the store moves one item a cycle while shifting.
// Reset clears the item count and cursor at once; stored words are not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
module cursor_sequence_store_core #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  css_pkg::css_req_type req_payload,
   output logic                 rsp_valid,
   output css_pkg::css_rsp_type rsp_payload
);
   import css_pkg::*;

   // The controller sequences each request through a small set of phases:
   // a shift phase that moves stored words one place up or down, a fill
   // phase that writes the new word into the opened gap, a memory read
   // phase for read requests, and a one-cycle response phase.
   css_cmd_type  cmd;
   css_stat_type stat;

   css_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the word store, the count and cursor, and the
   // shift address counters. It decides the whole outcome of a request
   // at acceptance, so count, cursor and status are final from then on;
   // only the memory traffic takes further cycles.
   css_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ dv/tb_cursor_sequence_store_core.sv @@
`timescale 1ns / 100ps

// Self-checking testbench for the cursor list store. A shadow copy of the list,
// its count and its cursor is kept here and stepped once for every request that the
// block accepts. The expected response is queued and compared field by field
// with each strobed response. The directed table runs first. The randomised part
// then cycles through filling, mixed and draining phases so that both the full
// store and the empty store are reached repeatedly.
module tb_cursor_sequence_store_core;
   import css_pkg::*;

   localparam int          DEPTH          = 64;
   localparam int          RANDOM_ITEMS   = 450;
   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          PRINT_LIMIT    = 40;
   // The highest request code that the port can carry. Codes above OP_READAT do nothing.
   localparam logic [3:0]  OP_UNUSED_LAST = 4'd15;

   typedef enum logic [1:0] {PHASE_FILL, PHASE_MIXED, PHASE_DRAIN} mix_phase_type;

   // One row of the directed table. When want_typed is set, the response written in
   // the row is expected. Otherwise the shadow list supplies the expectation.
   typedef struct {
      css_req_type req;
      bit          want_typed;
      css_rsp_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   css_req_type req_payload = '0;
   logic        rsp_valid;
   css_rsp_type rsp_payload;

   // Shadow of the list contents, the item count and the cursor.
   logic [63:0]   shadow_words [DEPTH];
   int            shadow_count  = 0;
   int            shadow_cursor = 0;

   css_rsp_type      pending_results [$];
   directed_row_type directed_rows [$];
   int               mismatch_count = 0;
   int               results_seen   = 0;
   int unsigned      cycle_count    = 0;

   cursor_sequence_store_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A watchdog bounds the whole run. The slowest correct run, with every request
   // shifting a full list and waiting out the longest gap, stays well below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // Applies one request to the shadow list and returns the response it should give.
   // Insertions and removals are turned into a shift position, and that position is
   // worked on once the operation has been decoded.
   function automatic css_rsp_type predict_list_step(input css_req_type r);
      css_rsp_type o;
      logic        has;
      logic        full;
      int          grow_at;
      int          shrink_at;
      o         = '0;
      has       = shadow_cursor < shadow_count;
      full      = shadow_count >= DEPTH;
      grow_at   = -1;
      shrink_at = -1;
      case (r.req_type)
         OP_START: begin
            shadow_cursor = 0;
         end
         OP_END: begin
            if (shadow_count == 0) o.status = ST_NONE;
            else shadow_cursor = shadow_count - 1;
         end
         OP_ADVANCE: begin
            if (!has) o.status = ST_NONE;
            else shadow_cursor++;
         end
         OP_INSERT: begin
            if (full) begin
               o.status = ST_FULL;
            end else begin
               if (!has) shadow_cursor = 0;
               grow_at = shadow_cursor;
            end
         end
         OP_ATTACH: begin
            if (full) begin
               o.status = ST_FULL;
            end else begin
               shadow_cursor = has ? shadow_cursor + 1 : shadow_count;
               grow_at       = shadow_cursor;
            end
         end
         OP_REMOVE: begin
            if (!has) o.status = ST_NONE;
            else shrink_at = shadow_cursor;
         end
         OP_INSFRONT: begin
            if (full) begin
               o.status = ST_FULL;
            end else begin
               grow_at       = 0;
               shadow_cursor = 0;
            end
         end
         OP_ATTBACK: begin
            if (full) begin
               o.status = ST_FULL;
            end else begin
               shadow_cursor = shadow_count;
               grow_at       = shadow_count;
            end
         end
         OP_REMFRONT: begin
            if (shadow_count == 0) begin
               o.status = ST_NONE;
            end else begin
               shrink_at     = 0;
               shadow_cursor = 0;
            end
         end
         OP_READ: begin
            if (!has) o.status = ST_NONE;
            else o.value = shadow_words[shadow_cursor];
         end
         OP_READAT: begin
            if (int'(r.spot) >= shadow_count) o.status = ST_NONE;
            else o.value = shadow_words[r.spot];
         end
         default: begin
         end
      endcase
      if (grow_at >= 0) begin
         for (int i = shadow_count; i > grow_at; i--) shadow_words[i] = shadow_words[i - 1];
         shadow_words[grow_at] = r.entry;
         shadow_count++;
      end
      if (shrink_at >= 0) begin
         for (int i = shrink_at; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
         shadow_count--;
      end
      o.count    = shadow_count[6:0];
      o.cursor   = shadow_cursor[6:0];
      o.has_item = shadow_cursor < shadow_count;
      return o;
   endfunction

   // Presents one request after a gap of idle cycles and returns once it has been taken.
   // With no gap, start simply stays high from the previous request, so that it is
   // never lowered and raised again within the same time step. The prediction is
   // made at the accepting edge, so the shadow list always follows what the block has
   // accepted.
   task automatic issue_request(input css_req_type r, input int gap,
                                output css_rsp_type predicted);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_list_step(r);
   endtask

   // Holds off further requests until every outstanding response has arrived.
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic void add_row(input css_req_type r, input bit typed,
                                   input css_rsp_type want);
      directed_row_type row;
      row.req        = r;
      row.want_typed = typed;
      row.want       = want;
      directed_rows.push_back(row);
   endfunction

   // Response checker. The receiver cannot stall, so every strobe is a response that
   // must match the oldest outstanding expectation.
   always @(posedge clock) begin
      css_rsp_type want;
      if (reset == 1'b0 && rsp_valid !== 1'b0) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding: %h",
                                      results_seen, rsp_payload));
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.value !== want.value)
               report_mismatch($sformatf("response %0d value %h, expected %h",
                                         results_seen, rsp_payload.value, want.value));
            if (rsp_payload.count !== want.count)
               report_mismatch($sformatf("response %0d count %0d, expected %0d",
                                         results_seen, rsp_payload.count, want.count));
            if (rsp_payload.cursor !== want.cursor)
               report_mismatch($sformatf("response %0d cursor %0d, expected %0d",
                                         results_seen, rsp_payload.cursor, want.cursor));
            if (rsp_payload.has_item !== want.has_item)
               report_mismatch($sformatf("response %0d has_item %b, expected %b",
                                         results_seen, rsp_payload.has_item, want.has_item));
            if (rsp_payload.status !== want.status)
               report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                         results_seen, rsp_payload.status, want.status));
         end
      end
   end

   initial begin
      css_req_type   req;
      css_rsp_type   predicted;
      mix_phase_type phase;
      int            sent;
      int            phase_step;
      int            phase_len;
      int            roll;
      int            limit_hits;
      bit            idle_on;

      // The directed table. Every request on the empty list that needs an item must
      // fail in the same way, unlike start and the unused code. An insert with no current
      // item goes to the front, and an advance past the last item leaves no current
      // item. The rows that follow cover attach with no current item, both ends of
      // the list and a read by position beyond the count. Each of these is checked
      // against the shadow list.
      add_row({OP_READ,     64'd0, 6'd0},  1'b1, {64'd0, 7'd0, 7'd0, 1'b0, ST_NONE});
      add_row({OP_END,      64'd0, 6'd0},  1'b1, {64'd0, 7'd0, 7'd0, 1'b0, ST_NONE});
      add_row({OP_ADVANCE,  64'd0, 6'd0},  1'b1, {64'd0, 7'd0, 7'd0, 1'b0, ST_NONE});
      add_row({OP_REMOVE,   64'd0, 6'd0},  1'b1, {64'd0, 7'd0, 7'd0, 1'b0, ST_NONE});
      add_row({OP_REMFRONT, 64'd0, 6'd0},  1'b1, {64'd0, 7'd0, 7'd0, 1'b0, ST_NONE});
      add_row({OP_READAT,   64'd0, 6'd0},  1'b1, {64'd0, 7'd0, 7'd0, 1'b0, ST_NONE});
      add_row({OP_START,    64'd0, 6'd0},  1'b1, {64'd0, 7'd0, 7'd0, 1'b0, ST_OK});
      add_row({OP_UNUSED_LAST, 64'hffff_ffff_ffff_ffff, 6'd63}, 1'b1,
              {64'd0, 7'd0, 7'd0, 1'b0, ST_OK});
      add_row({OP_INSERT,   64'hffff_ffff_ffff_ffff, 6'd0}, 1'b1,
              {64'd0, 7'd1, 7'd0, 1'b1, ST_OK});
      add_row({OP_READ,     64'd0, 6'd0},  1'b1,
              {64'hffff_ffff_ffff_ffff, 7'd1, 7'd0, 1'b1, ST_OK});
      add_row({OP_ATTACH,   64'd0, 6'd0},  1'b1, {64'd0, 7'd2, 7'd1, 1'b1, ST_OK});
      add_row({OP_ADVANCE,  64'd0, 6'd0},  1'b1, {64'd0, 7'd2, 7'd2, 1'b0, ST_OK});
      add_row({OP_INSERT,   64'h8000_0000_0000_0001, 6'd0}, 1'b0, '0);
      add_row({OP_END,      64'd0, 6'd0},  1'b0, '0);
      add_row({OP_ADVANCE,  64'd0, 6'd0},  1'b0, '0);
      add_row({OP_ATTACH,   64'h0123_4567_89ab_cdef, 6'd0}, 1'b0, '0);
      add_row({OP_INSFRONT, 64'h5555_5555_5555_5555, 6'd0}, 1'b0, '0);
      add_row({OP_ATTBACK,  64'haaaa_aaaa_aaaa_aaaa, 6'd0}, 1'b0, '0);
      add_row({OP_READAT,   64'd0, 6'd63}, 1'b0, '0);
      add_row({OP_READAT,   64'd0, 6'd0},  1'b0, '0);
      add_row({OP_REMOVE,   64'd0, 6'd0},  1'b0, '0);
      add_row({OP_REMFRONT, 64'd0, 6'd0},  1'b0, '0);
      add_row({OP_START,    64'd0, 6'd0},  1'b0, '0);
      add_row({OP_REMOVE,   64'd0, 6'd0},  1'b0, '0);
      add_row({OP_READ,     64'd0, 6'd0},  1'b0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].req, $urandom_range(0, 15), predicted);
         pending_results.push_back(directed_rows[i].want_typed ? directed_rows[i].want
                                                               : predicted);
      end
      wait_for_results();

      // Random part. Filling phases press on until the full store has been hit several
      // times, and draining phases do the same for the empty list. Each phase either
      // idles at random before every request or sends back to back. Between phases
      // the sender waits for every outstanding response.
      sent       = 0;
      phase_step = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase_step % 4)
            0:       phase = PHASE_FILL;
            2:       phase = PHASE_DRAIN;
            default: phase = PHASE_MIXED;
         endcase
         idle_on    = $urandom_range(0, 3) != 0;
         phase_len  = $urandom_range(30, 90);
         limit_hits = 0;
         for (int n = 0; n < 200 && sent < RANDOM_ITEMS; n++) begin
            if (phase == PHASE_MIXED && n >= phase_len) break;
            if (phase != PHASE_MIXED && limit_hits >= 6) break;
            roll = $urandom_range(0, 99);
            req  = '0;
            case (phase)
               PHASE_FILL: begin
                  if (roll < 80) begin
                     case ($urandom_range(0, 3))
                        0:       req.req_type = OP_INSERT;
                        1:       req.req_type = OP_ATTACH;
                        2:       req.req_type = OP_INSFRONT;
                        default: req.req_type = OP_ATTBACK;
                     endcase
                  end else begin
                     req.req_type = 4'($urandom_range(OP_START, OP_UNUSED_LAST));
                  end
                  if (shadow_count == DEPTH) limit_hits++;
               end
               PHASE_DRAIN: begin
                  if (roll < 30)      req.req_type = OP_REMFRONT;
                  else if (roll < 55) req.req_type = OP_REMOVE;
                  else if (roll < 75) req.req_type = 4'($urandom_range(OP_START, OP_ADVANCE));
                  else if (roll < 90) req.req_type = roll[0] ? OP_READ : OP_READAT;
                  else req.req_type = 4'($urandom_range(OP_START, OP_UNUSED_LAST));
                  if (shadow_count == 0) limit_hits++;
               end
               default: begin
                  if (roll < 85) req.req_type = 4'($urandom_range(OP_START, OP_READAT));
                  else           req.req_type = 4'($urandom_range(OP_START, OP_UNUSED_LAST));
               end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 6)       req.entry = '1;
            else if (roll < 12) req.entry = '0;
            else                req.entry = {$urandom(), $urandom()};
            // Half of the reads by position land inside the list, the rest anywhere.
            if (shadow_count > 0 && $urandom_range(0, 1) == 1)
               req.spot = 6'($urandom_range(0, shadow_count - 1));
            else
               req.spot = 6'($urandom_range(0, 63));
            issue_request(req, idle_on ? $urandom_range(0, 15) : 0, predicted);
            pending_results.push_back(predicted);
            sent++;
         end
         wait_for_results();
         phase_step++;
      end

      // Every response is in. A short settling time lets any stray strobe show up.
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/css_pkg.sv
sv/css_ctrl.sv
sv/css_dpath.sv
sv/cursor_sequence_store_core.sv
dv/tb_cursor_sequence_store_core.sv
